[sv/refresh_multiple_mode_selector_defines.svh]
// assertion macros for the refresh multiple mode selector
// used by rmms_queue and rmms_back; expects clk and arst_n in scope
`ifndef REFRESH_MULTIPLE_MODE_SELECTOR_DEFINES_SVH
`define REFRESH_MULTIPLE_MODE_SELECTOR_DEFINES_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define RMMS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define RMMS_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define RMMS_ASSERT(lbl, prop, msg)
`define RMMS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

[sv/rmms_pkg.sv]
// shared types and constants of the refresh multiple mode selector
// no dependencies
`timescale 1ns / 1ps
package rmms_pkg;

	// fixed field widths
	localparam int FRAME_W = 26;
	localparam int DIM_W   = 16;
	localparam int DEPTH_W = 7;

	// register indexes on the config port
	localparam logic [2:0] REG_FRAME_RATE = 3'd0;
	localparam logic [2:0] REG_USE_MAX    = 3'd1;
	localparam logic [2:0] REG_CUR_WIDTH  = 3'd2;
	localparam logic [2:0] REG_CUR_HEIGHT = 3'd3;
	localparam logic [2:0] REG_CUR_DEPTH  = 3'd4;
	localparam logic [2:0] REG_CUR_FREQ   = 3'd5;

	// nominal frequencies that stand for n+1 times 1000/1001 hz
	localparam logic [15:0] NTSC_F23  = 16'd23;
	localparam logic [15:0] NTSC_F29  = 16'd29;
	localparam logic [15:0] NTSC_F47  = 16'd47;
	localparam logic [15:0] NTSC_F59  = 16'd59;
	localparam logic [15:0] NTSC_F71  = 16'd71;
	localparam logic [15:0] NTSC_F95  = 16'd95;
	localparam logic [15:0] NTSC_F119 = 16'd119;

	// queue between front and back
	localparam int Q_DEPTH = 2;

	typedef struct packed {
		logic do_div;
		logic last;
	} rmms_cls_t;

	localparam int CLS_W = $bits(rmms_cls_t);

	typedef struct packed {
		logic full;
		logic empty;
	} rmms_q_status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_EVAL,
		BK_REPORT
	} rmms_bk_state_t;

endpackage

[sv/rmms_front.sv]
// front: geometry match, effective rate lookup and item classification
// depends on rmms_pkg
`timescale 1ns / 1ps
module rmms_front import rmms_pkg::*; #(
	parameter int RATE_FRAC_BITS = 16,
	parameter int FREQ_BITS      = 10,
	parameter int RATE_W         = FREQ_BITS + RATE_FRAC_BITS
) (
	input  logic [DIM_W-1:0]     mode_width,
	input  logic [DIM_W-1:0]     mode_height,
	input  logic [DEPTH_W-1:0]   mode_depth,
	input  logic [FREQ_BITS-1:0] mode_frequency,
	input  logic                 mode_last,
	input  logic [FRAME_W-1:0]   frame_rate,
	input  logic [DIM_W-1:0]     current_width,
	input  logic [DIM_W-1:0]     current_height,
	input  logic [DEPTH_W-1:0]   current_depth,
	output rmms_cls_t            cls,
	output logic [RATE_W-1:0]    rate,
	output logic [FREQ_BITS-1:0] freq
);

	// rounded (n+1)*1000*2^f/1001
	localparam longint unsigned R23  = ((64'd24000 << RATE_FRAC_BITS) + 64'd500) / 64'd1001;
	localparam longint unsigned R29  = ((64'd30000 << RATE_FRAC_BITS) + 64'd500) / 64'd1001;
	localparam longint unsigned R47  = ((64'd48000 << RATE_FRAC_BITS) + 64'd500) / 64'd1001;
	localparam longint unsigned R59  = ((64'd60000 << RATE_FRAC_BITS) + 64'd500) / 64'd1001;
	localparam longint unsigned R71  = ((64'd72000 << RATE_FRAC_BITS) + 64'd500) / 64'd1001;
	localparam longint unsigned R95  = ((64'd96000 << RATE_FRAC_BITS) + 64'd500) / 64'd1001;
	localparam longint unsigned R119 = ((64'd120000 << RATE_FRAC_BITS) + 64'd500) / 64'd1001;

	logic [15:0] freq_x;
	logic        match;

	assign freq_x = 16'(mode_frequency);
	assign match  = (mode_width == current_width) && (mode_height == current_height)
		&& (mode_depth == current_depth);

	always_comb begin
		unique case (freq_x)
			NTSC_F23:  rate = RATE_W'(R23);
			NTSC_F29:  rate = RATE_W'(R29);
			NTSC_F47:  rate = RATE_W'(R47);
			NTSC_F59:  rate = RATE_W'(R59);
			NTSC_F71:  rate = RATE_W'(R71);
			NTSC_F95:  rate = RATE_W'(R95);
			NTSC_F119: rate = RATE_W'(R119);
			default:   rate = {mode_frequency, {RATE_FRAC_BITS{1'b0}}};
		endcase
	end

	// zero rate or zero frame rate can never qualify, so skip the divider
	assign cls.do_div = match && (mode_frequency != '0) && (frame_rate != '0);
	assign cls.last   = mode_last;
	assign freq       = mode_frequency;

endmodule

[sv/rmms_queue.sv]
// small fifo between front and back
// depends on rmms_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "refresh_multiple_mode_selector_defines.svh"
module rmms_queue import rmms_pkg::*; #(
	parameter int WIDTH = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output rmms_q_status_t   status
);

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	assign pop_data     = mem_q[rd_ptr_q];
	assign status.full  = (count_q == CNT_W'(Q_DEPTH));
	assign status.empty = (count_q == '0);

	`RMMS_ASSERT_NEVER(a_q_overflow, push && status.full && !pop, "queue written while full")
	`RMMS_ASSERT_NEVER(a_q_underflow, pop && status.empty, "queue read while empty")
	`RMMS_ASSERT(a_q_count, count_q <= CNT_W'(Q_DEPTH), "queue count out of range")

endmodule

[sv/rmms_back.sv]
// back: one-bit-per-cycle divider, qualification, best-mode tracking, result register
// depends on rmms_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "refresh_multiple_mode_selector_defines.svh"
module rmms_back import rmms_pkg::*; #(
	parameter int RATE_FRAC_BITS = 16,
	parameter int FREQ_BITS      = 10,
	parameter int RATE_W         = FREQ_BITS + RATE_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rmms_q_status_t                      q_status,
	input  logic [CLS_W+RATE_W+FREQ_BITS-1:0]   q_data,
	output logic                                pop,
	input  logic [FRAME_W-1:0]                  frame_rate,
	input  logic                                use_max_multiple,
	input  logic [FREQ_BITS-1:0]                current_frequency,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                found,
	output logic [FREQ_BITS-1:0]                best_frequency,
	output logic                                already_current
);

	localparam int ENTRY_W = CLS_W + RATE_W + FREQ_BITS;
	localparam int DVD_W   = (((RATE_W + 1) > FRAME_W) ? (RATE_W + 1) : FRAME_W) + 1;
	localparam int DVS_W   = FRAME_W + 1;
	localparam int CNT_W   = $clog2(DVD_W + 1);
	localparam longint unsigned TOL = ((64'd15 << RATE_FRAC_BITS) + 64'd500) / 64'd1000;
	// remainder minus frame rate is twice the rate error
	localparam logic [DVS_W:0] TOL2 = (DVS_W + 1)'(TOL << 1);

	rmms_cls_t            e_cls;
	logic [RATE_W-1:0]    e_rate;
	logic [FREQ_BITS-1:0] e_freq;

	rmms_bk_state_t       state_q, state_d;
	logic [CNT_W-1:0]     cnt_q;
	logic [DVD_W-1:0]     dq_q;
	logic [DVS_W-1:0]     rem_q;
	logic [RATE_W-1:0]    rate_q;
	logic [FREQ_BITS-1:0] freq_q;
	logic                 last_q;
	logic                 have_best_q;
	logic [RATE_W-1:0]    best_rate_q;
	logic [FREQ_BITS-1:0] best_freq_q;
	logic                 out_valid_q;
	logic                 found_q;
	logic [FREQ_BITS-1:0] best_frequency_q;
	logic                 already_current_q;

	logic [DVS_W-1:0]     divisor;
	logic [DVS_W:0]       rem_sh;
	logic                 sub_ok;
	logic [DVS_W-1:0]     rem_nx;
	logic [DVD_W-1:0]     dividend;
	logic [DVS_W-1:0]     fr_x;
	logic [DVS_W-1:0]     err2;
	logic                 qual;
	logic                 better;
	logic                 take;
	logic                 out_free;

	assign e_cls  = rmms_cls_t'(q_data[ENTRY_W-1 -: CLS_W]);
	assign e_rate = q_data[RATE_W+FREQ_BITS-1 -: RATE_W];
	assign e_freq = q_data[FREQ_BITS-1:0];

	// restoring division step
	assign divisor  = {frame_rate, 1'b0};
	assign rem_sh   = {rem_q, dq_q[DVD_W-1]};
	assign sub_ok   = rem_sh >= {1'b0, divisor};
	assign rem_nx   = sub_ok ? DVS_W'(rem_sh - {1'b0, divisor}) : rem_sh[DVS_W-1:0];
	assign dividend = DVD_W'({e_rate, 1'b0}) + DVD_W'(frame_rate);

	// qualification from quotient and remainder
	assign fr_x   = DVS_W'(frame_rate);
	assign err2   = (rem_q >= fr_x) ? (rem_q - fr_x) : (fr_x - rem_q);
	assign qual   = (dq_q != '0) && (use_max_multiple || (dq_q == DVD_W'(1)))
		&& ({1'b0, err2} <= TOL2);
	assign better = use_max_multiple ? (rate_q > best_rate_q) : (rate_q < best_rate_q);
	assign take   = qual && (!have_best_q || better);

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_status.empty) begin
					pop = 1'b1;
					if (e_cls.do_div)
						state_d = BK_DIV;
					else if (e_cls.last)
						state_d = BK_REPORT;
				end
			end
			BK_DIV: begin
				if (cnt_q == CNT_W'(1))
					state_d = BK_EVAL;
			end
			BK_EVAL: begin
				state_d = last_q ? BK_REPORT : BK_IDLE;
			end
			BK_REPORT: begin
				if (out_free)
					state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			cnt_q       <= '0;
			have_best_q <= 1'b0;
			best_rate_q <= '0;
			best_freq_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop)
				cnt_q <= CNT_W'(DVD_W);
			else if (state_q == BK_DIV)
				cnt_q <= cnt_q - CNT_W'(1);
			if (state_q == BK_EVAL && take) begin
				have_best_q <= 1'b1;
				best_rate_q <= rate_q;
				best_freq_q <= freq_q;
			end else if (state_q == BK_REPORT && out_free) begin
				have_best_q <= 1'b0;
				best_rate_q <= '0;
				best_freq_q <= '0;
			end
			if (state_q == BK_REPORT && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rate_q <= e_rate;
			freq_q <= e_freq;
			last_q <= e_cls.last;
			dq_q   <= dividend;
			rem_q  <= '0;
		end else if (state_q == BK_DIV) begin
			dq_q  <= {dq_q[DVD_W-2:0], sub_ok};
			rem_q <= rem_nx;
		end
		if (state_q == BK_REPORT && out_free) begin
			found_q           <= have_best_q;
			best_frequency_q  <= have_best_q ? best_freq_q : '0;
			already_current_q <= have_best_q && (best_freq_q == current_frequency);
		end
	end

	assign out_valid       = out_valid_q;
	assign found           = found_q;
	assign best_frequency  = best_frequency_q;
	assign already_current = already_current_q;

	`RMMS_ASSERT(a_div_count, (state_q == BK_DIV) |-> (cnt_q != '0), "divider ran out of steps")
	`RMMS_ASSERT(a_report_clears, $rose(out_valid_q) |-> !have_best_q, "best not cleared on report")
	`RMMS_ASSERT(a_best_nonzero, have_best_q |-> (best_freq_q != '0), "zero frequency kept as best")
	`RMMS_ASSERT_NEVER(a_pop_busy, pop && (state_q != BK_IDLE), "queue read while busy")

endmodule

[sv/refresh_multiple_mode_selector.sv]
// top level of the refresh multiple mode selector: config registers and module wiring
// depends on rmms_pkg, rmms_front, rmms_queue and rmms_back
`timescale 1ns / 1ps
// picks the best refresh rate for a video frame rate out of a list of display modes.
// modes arrive one per input transaction; only those whose width, height and depth match
// the current mode are looked at. a matching mode with a nonzero frequency takes one queue
// pop, one division step per bit of the 2*rate+frame_rate dividend, i.e. max(rate width
// + 1, 26) + 1 steps, then an evaluation step; that bit-serial divider in the back end
// sets the throughput. modes that do not match, or have zero frequency or a zero frame
// rate, skip the divider. a two-entry queue between the classifier and the divider lets
// input transactions keep arriving while a division runs. the transaction carrying
// mode_last yields one result transaction (found, best_frequency, already_current),
// registered from the report state once the output is free and held in an output
// register until taken. config registers sit on a small apb port at byte address
// 4*index and should be written only while no list is in flight.
module refresh_multiple_mode_selector import rmms_pkg::*; #(
	parameter int RATE_FRAC_BITS = 16,
	parameter int FREQ_BITS      = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// apb config port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [4:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	// mode input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [DIM_W-1:0]     mode_width,
	input  logic [DIM_W-1:0]     mode_height,
	input  logic [DEPTH_W-1:0]   mode_depth,
	input  logic [FREQ_BITS-1:0] mode_frequency,
	input  logic                 mode_last,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 found,
	output logic [FREQ_BITS-1:0] best_frequency,
	output logic                 already_current
);

	localparam int RATE_W  = FREQ_BITS + RATE_FRAC_BITS;
	localparam int ENTRY_W = CLS_W + RATE_W + FREQ_BITS;

	// config registers
	logic [FRAME_W-1:0]   frame_rate_q;
	logic                 use_max_q;
	logic [DIM_W-1:0]     cur_width_q;
	logic [DIM_W-1:0]     cur_height_q;
	logic [DEPTH_W-1:0]   cur_depth_q;
	logic [FREQ_BITS-1:0] cur_freq_q;

	logic                 cfg_wr;
	logic [2:0]           cfg_idx;

	// front to queue
	rmms_cls_t            f_cls;
	logic [RATE_W-1:0]    f_rate;
	logic [FREQ_BITS-1:0] f_freq;
	logic                 push;
	logic [ENTRY_W-1:0]   push_data;

	// queue to back
	logic [ENTRY_W-1:0]   pop_data;
	logic                 pop;
	rmms_q_status_t       q_status;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[4:2];

	// register writes, out-of-range indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rate_q <= '0;
			use_max_q    <= 1'b1;
			cur_width_q  <= '0;
			cur_height_q <= '0;
			cur_depth_q  <= DEPTH_W'(32);
			cur_freq_q   <= FREQ_BITS'(60);
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_FRAME_RATE: frame_rate_q <= pwdata[FRAME_W-1:0];
				REG_USE_MAX:    use_max_q    <= pwdata[0];
				REG_CUR_WIDTH:  cur_width_q  <= pwdata[DIM_W-1:0];
				REG_CUR_HEIGHT: cur_height_q <= pwdata[DIM_W-1:0];
				REG_CUR_DEPTH:  cur_depth_q  <= pwdata[DEPTH_W-1:0];
				REG_CUR_FREQ:   cur_freq_q   <= pwdata[FREQ_BITS-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (cfg_idx)
			REG_FRAME_RATE: prdata = 32'(frame_rate_q);
			REG_USE_MAX:    prdata = 32'(use_max_q);
			REG_CUR_WIDTH:  prdata = 32'(cur_width_q);
			REG_CUR_HEIGHT: prdata = 32'(cur_height_q);
			REG_CUR_DEPTH:  prdata = 32'(cur_depth_q);
			REG_CUR_FREQ:   prdata = 32'(cur_freq_q);
			default:        prdata = '0;
		endcase
	end

	// classify each mode as it is accepted
	rmms_front #(
		.RATE_FRAC_BITS (RATE_FRAC_BITS),
		.FREQ_BITS      (FREQ_BITS),
		.RATE_W         (RATE_W)
	) u_front (
		.mode_width     (mode_width),
		.mode_height    (mode_height),
		.mode_depth     (mode_depth),
		.mode_frequency (mode_frequency),
		.mode_last      (mode_last),
		.frame_rate     (frame_rate_q),
		.current_width  (cur_width_q),
		.current_height (cur_height_q),
		.current_depth  (cur_depth_q),
		.cls            (f_cls),
		.rate           (f_rate),
		.freq           (f_freq)
	);

	// input stalls only when the queue is full
	assign in_stall  = q_status.full;
	assign push      = in_valid && !q_status.full;
	assign push_data = {f_cls, f_rate, f_freq};

	rmms_queue #(
		.WIDTH (ENTRY_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	// division, best tracking and result register
	rmms_back #(
		.RATE_FRAC_BITS (RATE_FRAC_BITS),
		.FREQ_BITS      (FREQ_BITS),
		.RATE_W         (RATE_W)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_status          (q_status),
		.q_data            (pop_data),
		.pop               (pop),
		.frame_rate        (frame_rate_q),
		.use_max_multiple  (use_max_q),
		.current_frequency (cur_freq_q),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.found             (found),
		.best_frequency    (best_frequency),
		.already_current   (already_current)
	);

endmodule
